### sv/stps_pkg.sv
`timescale 1ns / 1ps

package stps_pkg;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TICK,
    ST_WALK,
    ST_DRAIN,
    ST_CLEAR
  } state_t;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_TICK    = 2'd0;
  localparam opcode_t OP_ADD     = 2'd1;
  localparam opcode_t OP_CLR_PIN = 2'd2;
  localparam opcode_t OP_CLR_ALL = 2'd3;

  typedef logic [1:0] status_t;

  localparam status_t STS_OK    = 2'd0;
  localparam status_t STS_RANGE = 2'd1;
  localparam status_t STS_PIN   = 2'd2;

  localparam logic [10:0] SLOT_COUNT_RST = 11'd1000;

  localparam int unsigned OUT_W = 48;

  typedef logic [OUT_W-1:0] out_beat_t;

  function automatic out_beat_t pack_out(input logic wvalid, input logic clr,
                                         input logic [31:0] mask,
                                         input logic [9:0] slot,
                                         input status_t sts);
    pack_out = {2'b00, sts, slot, mask, clr, wvalid};
  endfunction

endpackage

### sv/slot_table_pulse_sequencer_top.sv
// Channel | Beat fields (low bit first)                      | Handshake
// in_     | tuser: opcode; tdata: pin, start_slot, pulse_width | tvalid/tready
// out_    | tdata: write_valid, to_clear_register, pin_mask,   | tvalid/tready
//         |        slot_index, status                          |
// cfg_    | wr_data: slot_count                                | wr_en, no wait
//
// Tick: one synchronous read of the slot memory, then the result register.
// Add pulse walks start..start+width, clear pin walks slot count slots, each then
// draining, one entry per cycle, read then write back; clear all writes slot count entries.
// Reset: a clearing pass writes all MAX_SLOTS entries, no beat accepted.
// A stalled result holds in the output register; the next beat is taken as it leaves.
`timescale 1ns / 1ps

module slot_table_pulse_sequencer_top
  import stps_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned PIN_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pin[4:0], start_slot[14:5], pulse_width[24:15]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // write_valid, to_clear_register, pin_mask[33:2],
                                  // slot_index[43:34], status[45:44]
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data // slot_count
);

  localparam int unsigned AW   = $clog2(MAX_SLOTS);
  localparam int unsigned CW0  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW   = (CW0 > 11) ? CW0 : 11;
  localparam int unsigned DW   = PIN_COUNT + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SLOTS - 1);

  logic [DW-1:0] mem [MAX_SLOTS];
  logic [DW-1:0] rd_data_r;

  state_t              state_r, state_nxt;
  logic [10:0]         slot_count_r;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [PIN_COUNT-1:0] pins_cfg_r, pins_cfg_nxt;
  logic [AW-1:0]       cur_r, cur_nxt;
  logic [AW-1:0]       last_r, last_nxt;
  logic [AW-1:0]       start_r, start_nxt;
  logic [PIN_COUNT-1:0] bit_r, bit_nxt;
  logic                add_r, add_nxt;
  logic [AW-1:0]       tick_slot_r, tick_slot_nxt;
  logic                wb_v_r, wb_v_nxt;
  logic [AW-1:0]       wb_addr_r, wb_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_data_r, out_data_nxt;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [DW-1:0]       wr_data;

  opcode_t             op;
  logic [4:0]          in_pin;
  logic [9:0]          in_start;
  logic [9:0]          in_width;
  logic [10:0]         pulse_end;
  logic [CW-1:0]       cnt;
  logic [AW-1:0]       cnt_last;
  logic [AW-1:0]       play;
  logic [CW-1:0]       play_inc;
  logic                pin_ok;
  logic [PIN_COUNT-1:0] pin_bit;
  logic                accept;
  logic [PIN_COUNT-1:0] wb_mask;
  logic                wb_act;

  assign op        = in_tuser;
  assign in_pin    = in_tdata[4:0];
  assign in_start  = in_tdata[14:5];
  assign in_width  = in_tdata[24:15];
  assign pulse_end = {1'b0, in_start} + {1'b0, in_width};

  always_comb begin
    if (slot_count_r < 11'd2) begin
      cnt = CW'(2);
    end else if (CW'(slot_count_r) > CW'(MAX_SLOTS)) begin
      cnt = CW'(MAX_SLOTS);
    end else begin
      cnt = CW'(slot_count_r);
    end
  end

  assign cnt_last = AW'(cnt - CW'(1));
  assign play     = (CW'(pos_r) >= cnt) ? '0 : pos_r;
  assign play_inc = CW'(play) + CW'(1);
  assign pin_ok   = {1'b0, in_pin} < 6'(PIN_COUNT);
  assign pin_bit  = PIN_COUNT'(32'd1 << in_pin);

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // read-modify-write of the walked slot
  always_comb begin
    wb_mask = rd_data_r[PIN_COUNT-1:0] & ~bit_r;
    wb_act  = rd_data_r[PIN_COUNT];
    if (add_r) begin
      if (wb_addr_r == last_r) begin
        wb_mask = rd_data_r[PIN_COUNT-1:0] | bit_r;
        wb_act  = 1'b1;
      end else if (wb_addr_r == start_r) begin
        wb_mask = rd_data_r[PIN_COUNT-1:0] | bit_r;
        wb_act  = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    pins_cfg_nxt  = pins_cfg_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    start_nxt     = start_r;
    bit_nxt       = bit_r;
    add_nxt       = add_r;
    tick_slot_nxt = tick_slot_r;
    wb_v_nxt      = 1'b0;
    wb_addr_nxt   = wb_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = cur_r;
    wr_en         = wb_v_r;
    wr_addr       = wb_addr_r;
    wr_data       = {wb_act, wb_mask};

    case (state_r)
      ST_INIT, ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = {1'b1, {PIN_COUNT{1'b0}}};
        if (cur_r == last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          cur_nxt = cur_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_TICK: begin
              rd_en         = 1'b1;
              rd_addr       = play;
              tick_slot_nxt = play;
              pos_nxt       = (play_inc >= cnt) ? '0 : AW'(play_inc);
              state_nxt     = ST_TICK;
            end
            OP_ADD: begin
              out_valid_nxt = 1'b1;
              if (!pin_ok) begin
                out_data_nxt = pack_out(1'b0, 1'b0, '0, '0, STS_PIN);
              end else if (CW'(pulse_end) >= cnt) begin
                out_data_nxt = pack_out(1'b0, 1'b0, '0, '0, STS_RANGE);
              end else begin
                if ((pins_cfg_r & pin_bit) == '0) begin
                  out_data_nxt = pack_out(1'b1, 1'b1, 32'(pin_bit), '0, STS_OK);
                end else begin
                  out_data_nxt = pack_out(1'b0, 1'b0, '0, '0, STS_OK);
                end
                pins_cfg_nxt = pins_cfg_r | pin_bit;
                start_nxt    = AW'(in_start);
                cur_nxt      = AW'(in_start);
                last_nxt     = AW'(pulse_end);
                bit_nxt      = pin_bit;
                add_nxt      = 1'b1;
                state_nxt    = ST_WALK;
              end
            end
            OP_CLR_PIN: begin
              out_valid_nxt = 1'b1;
              if (!pin_ok || ((pins_cfg_r & pin_bit) == '0)) begin
                out_data_nxt = pack_out(1'b0, 1'b0, '0, '0, STS_PIN);
              end else begin
                out_data_nxt = pack_out(1'b1, 1'b1, 32'(pin_bit), '0, STS_OK);
                start_nxt    = '0;
                cur_nxt      = '0;
                last_nxt     = cnt_last;
                bit_nxt      = pin_bit;
                add_nxt      = 1'b0;
                state_nxt    = ST_WALK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = pack_out(1'b0, 1'b0, '0, '0, STS_OK);
              cur_nxt       = '0;
              last_nxt      = cnt_last;
              state_nxt     = ST_CLEAR;
            end
          endcase
        end
      end
      ST_TICK: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = pack_out(1'b1, rd_data_r[PIN_COUNT],
                                 32'(rd_data_r[PIN_COUNT-1:0]), 10'(tick_slot_r), STS_OK);
        state_nxt     = ST_IDLE;
      end
      ST_WALK: begin
        rd_en       = 1'b1;
        rd_addr     = cur_r;
        wb_v_nxt    = 1'b1;
        wb_addr_nxt = cur_r;
        if (cur_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          cur_nxt = cur_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      slot_count_r <= SLOT_COUNT_RST;
      pos_r        <= '0;
      pins_cfg_r   <= '0;
      cur_r        <= '0;
      last_r       <= LAST_SLOT;
      wb_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      pins_cfg_r  <= pins_cfg_nxt;
      cur_r       <= cur_nxt;
      last_r      <= last_nxt;
      wb_v_r      <= wb_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        slot_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r     <= start_nxt;
    bit_r       <= bit_nxt;
    add_r       <= add_nxt;
    tick_slot_r <= tick_slot_nxt;
    wb_addr_r   <= wb_addr_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_no_wb_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !(wb_v_r && (state_r == ST_INIT || state_r == ST_CLEAR)))
    else $error("write-back overlaps a clearing sweep");

  a_no_wb_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !wb_v_r)
    else $error("beat accepted with a write-back pending");

  a_tick_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_TICK) |=> (state_r == ST_TICK))
    else $error("tick did not enter the read cycle");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |=> out_valid_r)
    else $error("tick result not loaded");

endmodule
